### sv/beat_pulse_light_assigner_macros.svh
// Assertion macros for the beat pulse light assigner.
`ifndef BEAT_PULSE_LIGHT_ASSIGNER_MACROS_SVH
`define BEAT_PULSE_LIGHT_ASSIGNER_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define BPLA_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("bpla assertion failed");
// Condition must never be true outside reset.
`define BPLA_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("bpla forbidden condition seen");
`else
`define BPLA_ASSERT(lbl, clk, rstn, prop)
`define BPLA_NEVER(lbl, clk, rstn, cond)
`endif
`endif

### sv/bpla_pkg.sv
// Shared types and constants of the beat pulse light assigner.
`default_nettype none
package bpla_pkg;
    localparam int BINS_DEF   = 64;
    localparam int LIGHTS_DEF = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_MAG_THR    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPREAD_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD       = 2'd2;

    localparam logic [7:0] MAG_THR_RST    = 8'd179;
    localparam logic [7:0] SPREAD_THR_RST = 8'd179;
    localparam logic [7:0] HOLD_RST       = 8'd16;

    localparam int VAL_W   = 16;
    localparam int NUM_W   = 6;
    localparam int OWNER_W = 7;
    localparam int HOLD_W  = 8;
    localparam logic [OWNER_W-1:0] NO_BIN_OUT = 7'd64;

    typedef struct packed {
        logic [HOLD_W-1:0]  hold;
        logic [OWNER_W-1:0] owner;
    } t_light;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MARK, ST_SRV_RD, ST_SRV, ST_ASG_RD, ST_ASG, ST_OUT
    } t_state;
endpackage
`default_nettype wire

### sv/bpla_in_if.sv
// Channel carrying one spectrum bin word.
`default_nettype none
interface bpla_in_if;
    logic                       valid;
    logic                       ready;
    logic [bpla_pkg::VAL_W-1:0] bin_mag;
    logic [bpla_pkg::VAL_W-1:0] bin_spread;
    logic [bpla_pkg::VAL_W-1:0] frame_mag_max;
    logic [bpla_pkg::VAL_W-1:0] frame_spread_max;
    logic                       clip_seen;
    logic                       frame_end;
    modport source (output valid, bin_mag, bin_spread, frame_mag_max, frame_spread_max,
                    clip_seen, frame_end, input ready);
    modport sink (input valid, bin_mag, bin_spread, frame_mag_max, frame_spread_max,
                  clip_seen, frame_end, output ready);
endinterface
`default_nettype wire

### sv/bpla_out_if.sv
// Channel carrying one light result word.
`default_nettype none
interface bpla_out_if;
    logic                         valid;
    logic                         ready;
    logic [bpla_pkg::NUM_W-1:0]   light_number;
    logic                         light_on;
    logic [bpla_pkg::OWNER_W-1:0] owned_bin;
    logic                         newly_assigned;
    logic                         last_light;
    modport source (output valid, light_number, light_on, owned_bin, newly_assigned,
                    last_light, input ready);
    modport sink (input valid, light_number, light_on, owned_bin, newly_assigned,
                  last_light, output ready);
endinterface
`default_nettype wire

### sv/beat_pulse_light_assigner.sv
// Top level of the beat pulse light assigner.
//
// The block takes one spectrum bin word per accepted transfer on i_in and, on the word
// that carries frame_end, sends one result word per light on o_out, light 0 first.
// A bin triggers when mag*256 exceeds mag_threshold times the frame maximum and the
// same holds for the spread. Bins past BINS in a frame are ignored.
// Ordinary bin words can be accepted back to back while the block is idle. The frame_end
// word starts a walk over the trigger bits to mark run centres (ST_MARK), then per light
// a read and a serve step (ST_SRV_RD, ST_SRV) to serve owners from the light state
// memory, then per light a read step (ST_ASG_RD), a search step per mark bit examined
// while looking for a free pulse (ST_ASG), and a step to present the result (ST_OUT).
// The light state memory, with one read and one write port, sets this pace.
// While the frame walk runs, i_in.ready is low. Each result waits in the output
// register until the receiver takes it; a stall simply holds the walk at that light.
// Reset (synchronous, active low) restores the register defaults, clears trigger bits,
// marks and the per-light valid bits, so every light reads as holding no bin.
// Configuration writes are taken at any time but are meant for idle periods only.
`default_nettype none
`include "beat_pulse_light_assigner_macros.svh"
module beat_pulse_light_assigner #(
    parameter int BINS   = bpla_pkg::BINS_DEF,
    parameter int LIGHTS = bpla_pkg::LIGHTS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [bpla_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [bpla_pkg::CFG_DATA_W-1:0] i_cfg_data,
    bpla_in_if.sink                              i_in,
    bpla_out_if.source                           o_out
);
    localparam int BW = $clog2(BINS);
    localparam int CW = $clog2(BINS + 1);
    localparam int LW = (LIGHTS > 1) ? $clog2(LIGHTS) : 1;
    localparam logic [CW-1:0] BINS_C = CW'(BINS);
    localparam logic [BW-1:0] TOP_BIN = BW'(BINS - 1);
    localparam logic [LW-1:0] LAST_L = LW'(LIGHTS - 1);
    localparam logic [bpla_pkg::OWNER_W-1:0] NONE_O = bpla_pkg::OWNER_W'(BINS);
    localparam int HOLD_W_L = bpla_pkg::HOLD_W;

    // Configuration registers.
    logic [7:0] r_mag_thr, r_spr_thr, r_hold_fr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag_thr <= bpla_pkg::MAG_THR_RST;
            r_spr_thr <= bpla_pkg::SPREAD_THR_RST;
            r_hold_fr <= bpla_pkg::HOLD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bpla_pkg::CFG_MAG_THR:    r_mag_thr <= i_cfg_data;
                bpla_pkg::CFG_SPREAD_THR: r_spr_thr <= i_cfg_data;
                bpla_pkg::CFG_HOLD:       r_hold_fr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bpla_pkg::t_state r_state, n_state;
    logic [CW-1:0]     r_cnt;
    logic [BINS-1:0]   r_trig, r_mark;
    logic [BW-1:0]     r_scan, r_start;
    logic [LW-1:0]     r_li;
    logic [CW-1:0]     r_j;
    logic [LIGHTS-1:0] r_served, r_lvalid;
    logic              r_clip;

    // Light state memory with a registered read at the current light.
    bpla_pkg::t_light r_mem [LIGHTS];
    bpla_pkg::t_light r_rdata;
    logic             r_rvalid;
    logic             mem_we;
    bpla_pkg::t_light mem_wdata;

    logic r_ovalid;
    logic [bpla_pkg::NUM_W-1:0]   r_onum;
    logic                         r_oon, r_onew, r_olast;
    logic [bpla_pkg::OWNER_W-1:0] r_obin;

    logic in_ready, in_acc, trig_now;
    logic [HOLD_W_L-1:0] rd_hold;
    logic [bpla_pkg::OWNER_W-1:0] rd_owner;
    logic srv_hit, take, asg_done;
    logic cur_t, prv_t;
    logic [BW-1:0] centre;
    logic [HOLD_W_L-1:0] h_a, h_d;
    logic [bpla_pkg::OWNER_W-1:0] o_a, o_d;
    logic s_a, on_d;

    assign in_acc = i_in.valid && in_ready;
    assign trig_now = ({i_in.bin_mag, 8'd0} > (24'(r_mag_thr) * 24'(i_in.frame_mag_max))) &&
                      ({i_in.bin_spread, 8'd0} >
                       (24'(r_spr_thr) * 24'(i_in.frame_spread_max)));

    assign rd_hold  = r_rvalid ? r_rdata.hold  : '0;
    assign rd_owner = r_rvalid ? r_rdata.owner : NONE_O;
    assign srv_hit  = (rd_owner < NONE_O) && r_mark[rd_owner[BW-1:0]];
    assign take     = (rd_hold == '0) && (r_j < BINS_C) && r_mark[r_j[BW-1:0]];
    assign asg_done = (rd_hold != '0) || (r_j == BINS_C) || take;

    // Run edges during the centre-marking walk.
    assign cur_t  = r_trig[r_scan];
    assign prv_t  = r_trig[r_scan - BW'(1)];
    assign centre = r_start + ((r_scan - r_start) >> 1);

    // Assignment, then decay of an unserved light.
    always_comb begin
        h_a = rd_hold;
        o_a = rd_owner;
        s_a = r_served[r_li];
        if (take) begin
            h_a = r_hold_fr;
            o_a = bpla_pkg::OWNER_W'(r_j);
            s_a = 1'b1;
        end
        h_d  = h_a;
        o_d  = o_a;
        on_d = 1'b1;
        if (!s_a) begin
            on_d = 1'b0;
            if (h_a == '0) begin
                o_d = NONE_O;
            end else begin
                h_d = h_a - 8'd1;
            end
            if (r_clip && (h_d < (r_hold_fr >> 1))) begin
                on_d = 1'b1;
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            bpla_pkg::ST_IDLE:   if (in_acc && i_in.frame_end) n_state = bpla_pkg::ST_MARK;
            bpla_pkg::ST_MARK:   if (r_scan == TOP_BIN) n_state = bpla_pkg::ST_SRV_RD;
            bpla_pkg::ST_SRV_RD: n_state = bpla_pkg::ST_SRV;
            bpla_pkg::ST_SRV:    n_state = (r_li == LAST_L) ? bpla_pkg::ST_ASG_RD
                                                            : bpla_pkg::ST_SRV_RD;
            bpla_pkg::ST_ASG_RD: n_state = bpla_pkg::ST_ASG;
            bpla_pkg::ST_ASG:    if (asg_done) n_state = bpla_pkg::ST_OUT;
            bpla_pkg::ST_OUT: begin
                if (o_out.ready) begin
                    n_state = (r_li == LAST_L) ? bpla_pkg::ST_IDLE : bpla_pkg::ST_ASG_RD;
                end
            end
            default: n_state = bpla_pkg::ST_IDLE;
        endcase
    end

    // Control outputs of the state machine.
    always_comb begin
        in_ready  = 1'b0;
        mem_we    = 1'b0;
        mem_wdata = '{hold: h_d, owner: o_d};
        case (r_state)
            bpla_pkg::ST_IDLE: in_ready = 1'b1;
            bpla_pkg::ST_SRV: begin
                mem_we    = srv_hit;
                mem_wdata = '{hold: r_hold_fr, owner: rd_owner};
            end
            bpla_pkg::ST_ASG: mem_we = asg_done;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_li] <= mem_wdata;
        end
        r_rdata <= r_mem[r_li];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvalid <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (mem_we) begin
                r_lvalid[r_li] <= 1'b1;
            end
            r_rvalid <= r_lvalid[r_li];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bpla_pkg::ST_IDLE;
            r_cnt    <= '0;
            r_trig   <= '0;
            r_mark   <= '0;
            r_scan   <= '0;
            r_start  <= '0;
            r_li     <= '0;
            r_j      <= '0;
            r_served <= '0;
            r_clip   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                bpla_pkg::ST_IDLE: begin
                    if (in_acc) begin
                        if (r_cnt < BINS_C) begin
                            r_trig[r_cnt[BW-1:0]] <= trig_now;
                            r_cnt <= r_cnt + CW'(1);
                        end
                        if (i_in.frame_end) begin
                            r_clip   <= i_in.clip_seen;
                            r_mark   <= '0;
                            r_served <= '0;
                            r_scan   <= BW'(1);
                            r_start  <= '0;
                        end
                    end
                end
                bpla_pkg::ST_MARK: begin
                    if (cur_t && !prv_t) begin
                        r_start <= r_scan;
                    end else if (!cur_t && prv_t) begin
                        r_mark[centre] <= 1'b1;
                    end
                    if (r_scan == TOP_BIN) begin
                        r_trig <= '0;
                        r_cnt  <= '0;
                        r_li   <= '0;
                    end else begin
                        r_scan <= r_scan + BW'(1);
                    end
                end
                bpla_pkg::ST_SRV: begin
                    if (srv_hit) begin
                        r_served[r_li] <= 1'b1;
                        r_mark[rd_owner[BW-1:0]] <= 1'b0;
                    end
                    r_li <= (r_li == LAST_L) ? '0 : r_li + LW'(1);
                    r_j  <= '0;
                end
                bpla_pkg::ST_ASG: begin
                    if (take) begin
                        r_mark[r_j[BW-1:0]] <= 1'b0;
                    end
                    if (asg_done) begin
                        r_ovalid <= 1'b1;
                        r_onum   <= bpla_pkg::NUM_W'(r_li);
                        r_oon    <= on_d;
                        r_obin   <= (o_d < NONE_O) ? o_d : bpla_pkg::NO_BIN_OUT;
                        r_onew   <= take;
                        r_olast  <= (r_li == LAST_L);
                    end else begin
                        r_j <= r_j + CW'(1);
                    end
                end
                bpla_pkg::ST_OUT: begin
                    if (o_out.ready) begin
                        r_ovalid <= 1'b0;
                        if (r_li != LAST_L) begin
                            r_li <= r_li + LW'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign i_in.ready           = in_ready;
    assign o_out.valid          = r_ovalid;
    assign o_out.light_number   = r_onum;
    assign o_out.light_on       = r_oon;
    assign o_out.owned_bin      = r_obin;
    assign o_out.newly_assigned = r_onew;
    assign o_out.last_light     = r_olast;

    // Input and output never run together during a frame walk.
    `BPLA_NEVER(a_no_overlap, i_clk, i_rst_n, i_in.ready && o_out.valid)
    // A newly assigned light is always lit.
    `BPLA_ASSERT(a_new_lit, i_clk, i_rst_n, (o_out.valid && o_out.newly_assigned) |-> o_out.light_on)
    // The final result hands control back to the input side.
    `BPLA_ASSERT(a_back_idle, i_clk, i_rst_n, (o_out.valid && o_out.ready && o_out.last_light) |=> i_in.ready)
endmodule
`default_nettype wire

### verif/bpla_checker.sv
// Checker for the beat pulse light assigner: predicts light words and compares them.
`timescale 1ns / 100ps
module bpla_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [7:0]    i_cfg_data,
    bpla_in_if.sink       i_in_mon,
    bpla_out_if.sink      i_out_mon,
    output int            o_fail_count,
    output int            o_pending
);
    localparam int NB = bpla_pkg::BINS_DEF;
    localparam int NL = bpla_pkg::LIGHTS_DEF;

    typedef struct packed {
        logic [5:0] light_number;
        logic       light_on;
        logic [6:0] owned_bin;
        logic       newly_assigned;
        logic       last_light;
    } t_light_word;

    t_light_word light_words_q[$];
    logic [7:0] mag_thr, spread_thr, hold_cfg;
    int         bin_cnt;
    logic [NB-1:0] trig;
    logic [7:0] hold_st[NL];
    int         owner_st[NL];
    int         fails;

    assign o_fail_count = fails;
    assign o_pending    = light_words_q.size();

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        fails++;
    endtask

    task automatic predict_frame(input logic clip);
        logic [NB-1:0] marks;
        logic served[NL];
        logic newly[NL];
        int start, c, o;
        t_light_word w;
        marks = '0;
        start = 0;
        for (int i = 1; i < NB; i++) begin
            if (trig[i] && !trig[i-1]) start = i;
            else if (!trig[i] && trig[i-1]) begin
                c = (i - start) / 2 + start;
                marks[c] = 1'b1;
            end
        end
        for (int i = 0; i < NL; i++) begin
            served[i] = 0; newly[i] = 0;
        end
        for (int i = 0; i < NL; i++) begin
            o = owner_st[i];
            if (o < NB && marks[o]) begin
                served[i] = 1; hold_st[i] = hold_cfg; marks[o] = 0;
            end
        end
        for (int i = 0; i < NL; i++) begin
            if (hold_st[i] == 0) begin
                for (int j = 0; j < NB; j++) begin
                    if (marks[j]) begin
                        served[i] = 1; hold_st[i] = hold_cfg; owner_st[i] = j;
                        newly[i] = 1; marks[j] = 0;
                        break;
                    end
                end
            end
        end
        for (int i = 0; i < NL; i++) begin
            w.light_on = 1'b1;
            if (!served[i]) begin
                w.light_on = 1'b0;
                if (hold_st[i] == 0) owner_st[i] = NB;
                else hold_st[i] = hold_st[i] - 8'd1;
                if (clip && hold_st[i] < (hold_cfg >> 1)) w.light_on = 1'b1;
            end
            w.light_number   = i[5:0];
            w.owned_bin      = (owner_st[i] < NB) ? 7'(owner_st[i]) : bpla_pkg::NO_BIN_OUT;
            w.newly_assigned = newly[i];
            w.last_light     = (i == NL - 1);
            light_words_q.push_back(w);
        end
        trig = '0;
        bin_cnt = 0;
    endtask

    always @(posedge i_clk) begin
        t_light_word got, exp_w;
        logic t;
        if (!i_rst_n) begin
            mag_thr = bpla_pkg::MAG_THR_RST;
            spread_thr = bpla_pkg::SPREAD_THR_RST;
            hold_cfg = bpla_pkg::HOLD_RST;
            bin_cnt = 0; trig = '0; fails = fails;
            light_words_q.delete();
            for (int i = 0; i < NL; i++) begin
                hold_st[i] = 0; owner_st[i] = NB;
            end
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                got = {i_out_mon.light_number, i_out_mon.light_on, i_out_mon.owned_bin,
                       i_out_mon.newly_assigned, i_out_mon.last_light};
                if (light_words_q.size() == 0) begin
                    report_mismatch("light word with nothing expected");
                end else begin
                    exp_w = light_words_q.pop_front();
                    if (got.light_number !== exp_w.light_number)
                        report_mismatch($sformatf("light_number %0d exp %0d",
                            got.light_number, exp_w.light_number));
                    if (got.light_on !== exp_w.light_on)
                        report_mismatch($sformatf("light %0d on %b exp %b",
                            exp_w.light_number, got.light_on, exp_w.light_on));
                    if (got.owned_bin !== exp_w.owned_bin)
                        report_mismatch($sformatf("light %0d bin %0d exp %0d",
                            exp_w.light_number, got.owned_bin, exp_w.owned_bin));
                    if (got.newly_assigned !== exp_w.newly_assigned)
                        report_mismatch($sformatf("light %0d newly %b exp %b",
                            exp_w.light_number, got.newly_assigned,
                            exp_w.newly_assigned));
                    if (got.last_light !== exp_w.last_light)
                        report_mismatch($sformatf("light %0d last %b exp %b",
                            exp_w.light_number, got.last_light, exp_w.last_light));
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                if (bin_cnt < NB) begin
                    t = ({i_in_mon.bin_mag, 8'd0} >
                         (24'(mag_thr) * 24'(i_in_mon.frame_mag_max)))
                     && ({i_in_mon.bin_spread, 8'd0} >
                         (24'(spread_thr) * 24'(i_in_mon.frame_spread_max)));
                    trig[bin_cnt] = t;
                    bin_cnt++;
                end
                if (i_in_mon.frame_end) predict_frame(i_in_mon.clip_seen);
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bpla_pkg::CFG_MAG_THR:    mag_thr    = i_cfg_data;
                    bpla_pkg::CFG_SPREAD_THR: spread_thr = i_cfg_data;
                    bpla_pkg::CFG_HOLD:       hold_cfg   = i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    initial fails = 0;
endmodule

### verif/tb_top.sv
// Testbench top for the beat pulse light assigner: stimulus, idling and verdict.
`timescale 1ns / 100ps
module tb_top;
    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = bpla_pkg::CFG_MAG_THR;
    logic [7:0] i_cfg_data = '0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int fail_count, pending;
    int quiet_cycles = 0;
    localparam int WATCHDOG = 20000;

    bpla_in_if  in_ch();
    bpla_out_if out_ch();

    beat_pulse_light_assigner DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    bpla_checker light_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_in_mon(in_ch.sink), .i_out_mon(out_ch.sink),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The receiver stalls at random with the current percentage; decided afresh each edge.
    initial out_ch.ready = 1'b0;
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // The watchdog counts cycles in which no word moves on either channel.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("[beat_pulse_light_assigner] ERROR");
            $finish;
        end
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.bin_mag = '0;
        in_ch.bin_spread = '0;
        in_ch.frame_mag_max = '0;
        in_ch.frame_spread_max = '0;
        in_ch.clip_seen = 1'b0;
        in_ch.frame_end = 1'b0;
    end

    // Presents one bin word after a random idle gap and holds it until it is accepted.
    // Valid stays high after acceptance so that a following word can go back to back;
    // an idle gap or the drain task takes it down.
    task automatic send_bin(input logic [15:0] mag, input logic [15:0] spread,
                            input logic [15:0] mmax, input logic [15:0] smax,
                            input logic clip, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.bin_mag <= mag;
        in_ch.bin_spread <= spread;
        in_ch.frame_mag_max <= mmax;
        in_ch.frame_spread_max <= smax;
        in_ch.clip_seen <= clip;
        in_ch.frame_end <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // Waits until every expected light word has come, then lets the walk settle.
    task automatic drain;
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // One frame of well-formed content: triggered runs over a background of quiet bins.
    // The run density and the frame length vary, and now and then bins overflow.
    task automatic send_frame(input int nbins);
        logic [15:0] mmax, smax, mag, spread;
        bit hot;
        int density;
        mmax = 16'($urandom_range(65535));
        smax = 16'($urandom_range(65535));
        density = $urandom_range(10, 60);
        hot = 0;
        for (int b = 0; b < nbins; b++) begin
            if ($urandom_range(99) < density) hot = !hot;
            if ($urandom_range(19) == 0) begin
                mag = 16'($urandom); spread = 16'($urandom);
            end else if (hot) begin
                mag = mmax - 16'($urandom_range(mmax / 8));
                spread = smax - 16'($urandom_range(smax / 8));
            end else begin
                mag = 16'($urandom_range(mmax / 2)); spread = 16'($urandom_range(65535));
            end
            send_bin(mag, spread, mmax, smax, 1'($urandom_range(1)), b == nbins - 1);
        end
    endtask

    int nb;

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: extremes of the fields, zero maxima, a run open at the top bin,
        // a short frame and the reset thresholds. Then hold_frames at zero and at its top.
        send_bin(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
        send_bin(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
        send_bin(16'h0001, 16'h0001, 16'h0000, 16'h0000, 1'b0, 1'b0);
        send_bin(16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 1'b1, 1'b1);
        drain();
        for (int b = 0; b < 64; b++)
            send_bin(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 1'b1, b == 63);
        drain();
        send_bin(16'h0000, 16'h0000, 16'h1234, 16'h1234, 1'b1, 1'b1);
        drain();
        write_reg(bpla_pkg::CFG_HOLD, 8'd0);
        write_reg(bpla_pkg::CFG_MAG_THR, 8'd0);
        write_reg(bpla_pkg::CFG_SPREAD_THR, 8'd255);
        send_frame(12);
        drain();
        write_reg(bpla_pkg::CFG_HOLD, 8'd255);
        write_reg(bpla_pkg::CFG_MAG_THR, 8'd255);
        write_reg(bpla_pkg::CFG_SPREAD_THR, 8'd0);
        send_frame(8);
        drain();

        // Random phases over the idling mixes and several register settings.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            write_reg(bpla_pkg::CFG_MAG_THR,
                      (ph == 4) ? 8'd1 : 8'($urandom_range(100, 220)));
            write_reg(bpla_pkg::CFG_SPREAD_THR,
                      (ph == 5) ? 8'd254 : 8'($urandom_range(100, 220)));
            write_reg(bpla_pkg::CFG_HOLD, (ph == 6) ? 8'd1 : 8'($urandom_range(1, 6)));
            for (int f = 0; f < 2; f++) begin
                nb = ($urandom_range(9) == 0) ? $urandom_range(60, 70) : $urandom_range(2, 9);
                send_frame(nb);
            end
            // The sender holds off here until every light word has arrived.
            drain();
        end

        recv_stall_pct = 0;
        drain();
        if (fail_count == 0) begin
            $display("[beat_pulse_light_assigner] OK");
        end else begin
            $display("[beat_pulse_light_assigner] ERROR");
        end
        $finish;
    end
endmodule
